### hw/rtl/hicp_pkg.sv
// Shared types and constants for the hash index overflow chain core.
package hicp_pkg;

    localparam int DEF_MAX_BUCKETS       = 256;
    localparam int DEF_POOL_PAGES        = 1024;
    localparam int DEF_MAX_RECS_PER_PAGE = 8;
    localparam int DEF_PAYLOAD_BITS      = 64;

    localparam int KEY_W      = 31;
    localparam int BC_W       = 9;
    localparam int RPP_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int DIV_CNT_W  = 5;

    localparam logic [BC_W-1:0]      BC_RESET          = 9'd256;
    localparam logic [RPP_W-1:0]     RPP_RESET         = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECS_PER_PAGE = 1'd1;
    localparam logic                 MODE_INSERT       = 1'b0;
    localparam logic                 MODE_LOOKUP       = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_POOL_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_NOT_FOUND,
        RES_POOL_FULL,
        RES_FOUND
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_META_RD,
        ST_META_CHK,
        ST_LINK,
        ST_ALLOC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic div_step;
        logic page_from_head;
        logic page_from_next;
        logic head_wr;
        logic link_wr;
        logic alloc_wr;
        logic rec_app;
        logic idx_clr;
        logic idx_inc;
        logic res_set;
        res_t res_kind;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic div_last;
        logic head_valid;
        logic pool_full;
        logic next_valid;
        logic page_full;
        logic idx_end;
        logic key_match;
        logic out_hold;
    } dp_sts_t;

endpackage

### hw/rtl/hicp_ctrl.sv
// Operation sequencer for the hash index overflow chain core.
module hicp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  hicp_pkg::dp_sts_t sts,
    output hicp_pkg::dp_cmd_t cmd
);
    import hicp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_CHK;
            end
            ST_HEAD_CHK:
            begin
                if (!sts.head_valid)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                    if (sts.mode == MODE_LOOKUP)
                    begin
                        cmd.res_kind = RES_NOT_FOUND;
                    end
                    else if (sts.pool_full)
                    begin
                        cmd.res_kind = RES_POOL_FULL;
                    end
                    else
                    begin
                        cmd.head_wr  = 1'b1;
                        cmd.alloc_wr = 1'b1;
                        cmd.res_kind = RES_OK;
                    end
                end
                else
                begin
                    cmd.page_from_head = 1'b1;
                    state_next         = ST_META_RD;
                end
            end
            ST_META_RD:
            begin
                state_next = ST_META_CHK;
            end
            ST_META_CHK:
            begin
                if (sts.mode == MODE_LOOKUP)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
                else if (sts.next_valid)
                begin
                    cmd.page_from_next = 1'b1;
                    state_next         = ST_META_RD;
                end
                else if (sts.page_full)
                begin
                    if (sts.pool_full)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_POOL_FULL;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    cmd.rec_app  = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_OK;
                    state_next   = ST_DONE;
                end
            end
            ST_LINK:
            begin
                cmd.link_wr = 1'b1;
                state_next  = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                cmd.alloc_wr = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_OK;
                state_next   = ST_DONE;
            end
            ST_SCAN_RD:
            begin
                if (sts.idx_end)
                begin
                    if (sts.next_valid)
                    begin
                        cmd.page_from_next = 1'b1;
                        state_next         = ST_META_RD;
                    end
                    else
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_NOT_FOUND;
                        state_next   = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (sts.key_match)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_FOUND;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_hold)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !sts.div_last |=> state_reg == ST_DIV)
        else $error("divider left early");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LINK |=> state_reg == ST_ALLOC)
        else $error("link not followed by page allocation");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && sts.out_hold |=> state_reg == ST_DONE)
        else $error("result dropped while output held");

endmodule

### hw/rtl/hicp_dp.sv
// Datapath: bucket divider, head/page/record memories and result register.
module hicp_dp #(
    parameter int MAX_BUCKETS       = hicp_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_PAGES        = hicp_pkg::DEF_POOL_PAGES,
    parameter int MAX_RECS_PER_PAGE = hicp_pkg::DEF_MAX_RECS_PER_PAGE,
    parameter int PAYLOAD_BITS      = hicp_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hicp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hicp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             mode,
    input  logic [hicp_pkg::KEY_W-1:0]       key,
    input  logic [PAYLOAD_BITS-1:0]          payload,
    input  hicp_pkg::dp_cmd_t                cmd,
    output hicp_pkg::dp_sts_t                sts,
    output logic [1:0]                       status,
    output logic [hicp_pkg::KEY_W-1:0]       found_key,
    output logic [PAYLOAD_BITS-1:0]          found_payload,
    output logic                             out_valid,
    input  logic                             out_stall
);
    import hicp_pkg::*;

    localparam int DVW = $clog2(MAX_BUCKETS + 1);
    localparam int BIW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PW  = $clog2(POOL_PAGES);
    localparam int AW  = $clog2(POOL_PAGES + 1);
    localparam int FW  = $clog2(MAX_RECS_PER_PAGE + 1);
    localparam int MW  = 1 + PW + FW;
    localparam int RIW = $clog2(POOL_PAGES * MAX_RECS_PER_PAGE);
    localparam logic [RIW-1:0] RECS_C = RIW'(MAX_RECS_PER_PAGE);

    // config
    logic [BC_W-1:0]  bc_reg;
    logic [RPP_W-1:0] rpp_reg;
    logic [DVW-1:0]   eff_div;
    logic [FW-1:0]    eff_rpp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg  <= BC_RESET;
            rpp_reg <= RPP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUCKET_COUNT:  bc_reg  <= cfg_data;
                REG_RECS_PER_PAGE: rpp_reg <= cfg_data[RPP_W-1:0];
                default:           bc_reg  <= bc_reg;
            endcase
        end
    end

    always_comb
    begin
        if (bc_reg == '0)
            eff_div = DVW'(1);
        else if (32'(bc_reg) > 32'(MAX_BUCKETS))
            eff_div = DVW'(MAX_BUCKETS);
        else
            eff_div = DVW'(bc_reg);
        if (rpp_reg == '0)
            eff_rpp = FW'(1);
        else if (32'(rpp_reg) > 32'(MAX_RECS_PER_PAGE))
            eff_rpp = FW'(MAX_RECS_PER_PAGE);
        else
            eff_rpp = FW'(rpp_reg);
    end

    // transaction latch and bit-serial remainder
    logic                    mode_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [KEY_W-1:0]        div_sh_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [DVW:0]            rem_reg;
    logic [DVW:0]            rem_trial;
    logic [BIW-1:0]          bucket;

    assign rem_trial = {rem_reg[DVW-1:0], div_sh_reg[KEY_W-1]};
    assign bucket    = rem_reg[BIW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            pay_reg  <= payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_sh_reg  <= '0;
            div_cnt_reg <= '0;
            rem_reg     <= '0;
        end
        else if (cmd.start)
        begin
            div_sh_reg  <= key;
            div_cnt_reg <= DIV_CNT_W'(KEY_W);
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            div_sh_reg  <= {div_sh_reg[KEY_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            if (rem_trial >= {1'b0, eff_div})
                rem_reg <= rem_trial - {1'b0, eff_div};
            else
                rem_reg <= rem_trial;
        end
    end

    // bucket heads
    logic [PW-1:0]   head_mem [MAX_BUCKETS];
    logic [PW-1:0]   head_q;
    logic [MAX_BUCKETS-1:0] head_valid_reg;
    logic [AW-1:0]   alloc_cnt_reg;
    logic [PW-1:0]   fresh;

    assign fresh = alloc_cnt_reg[PW-1:0];

    always_ff @(posedge clk)
    begin
        head_q <= head_mem[bucket];
        if (cmd.head_wr)
            head_mem[bucket] <= fresh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            alloc_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.head_wr)
                head_valid_reg[bucket] <= 1'b1;
            if (cmd.alloc_wr)
                alloc_cnt_reg <= alloc_cnt_reg + AW'(1);
        end
    end

    // page metadata: {next valid, next page, fill}
    logic [MW-1:0] meta_mem [POOL_PAGES];
    logic [MW-1:0] meta_q;
    logic [PW-1:0] page_reg;
    logic          meta_nv;
    logic [PW-1:0] meta_next;
    logic [FW-1:0] meta_fill;
    logic          meta_we;
    logic [PW-1:0] meta_waddr;
    logic [MW-1:0] meta_wdata;

    assign meta_nv   = meta_q[MW-1];
    assign meta_next = meta_q[FW +: PW];
    assign meta_fill = meta_q[FW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.page_from_head)
            page_reg <= head_q;
        else if (cmd.page_from_next)
            page_reg <= meta_next;
    end

    always_comb
    begin
        meta_we    = cmd.alloc_wr | cmd.link_wr | cmd.rec_app;
        meta_waddr = page_reg;
        meta_wdata = {meta_nv, meta_next, meta_fill + FW'(1)};
        if (cmd.alloc_wr)
        begin
            meta_waddr = fresh;
            meta_wdata = {1'b0, PW'(0), FW'(1)};
        end
        else if (cmd.link_wr)
        begin
            meta_wdata = {1'b1, fresh, meta_fill};
        end
    end

    always_ff @(posedge clk)
    begin
        meta_q <= meta_mem[page_reg];
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
    end

    // record store
    logic [KEY_W-1:0]        rkey_mem [POOL_PAGES * MAX_RECS_PER_PAGE];
    logic [PAYLOAD_BITS-1:0] rpay_mem [POOL_PAGES * MAX_RECS_PER_PAGE];
    logic [KEY_W-1:0]        rkey_q;
    logic [PAYLOAD_BITS-1:0] rpay_q;
    logic [FW-1:0]           idx_reg;
    logic [RIW-1:0]          rd_addr;
    logic [RIW-1:0]          wr_addr;
    logic                    rec_we;

    assign rd_addr = RIW'(page_reg) * RECS_C + RIW'(idx_reg);
    assign rec_we  = cmd.alloc_wr | cmd.rec_app;
    assign wr_addr = cmd.alloc_wr ? RIW'(fresh) * RECS_C
                                  : RIW'(page_reg) * RECS_C + RIW'(meta_fill);

    always_ff @(posedge clk)
    begin
        if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + FW'(1);
    end

    always_ff @(posedge clk)
    begin
        rkey_q <= rkey_mem[rd_addr];
        rpay_q <= rpay_mem[rd_addr];
        if (rec_we)
        begin
            rkey_mem[wr_addr] <= key_reg;
            rpay_mem[wr_addr] <= pay_reg;
        end
    end

    // result
    res_t                    res_kind_reg;
    status_t                 status_reg;
    logic [KEY_W-1:0]        fkey_reg;
    logic [PAYLOAD_BITS-1:0] fpay_reg;
    logic                    out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
            res_kind_reg <= cmd.res_kind;
        if (cmd.res_load)
        begin
            unique case (res_kind_reg)
                RES_OK:        status_reg <= STATUS_OK;
                RES_FOUND:     status_reg <= STATUS_OK;
                RES_NOT_FOUND: status_reg <= STATUS_NOT_FOUND;
                default:       status_reg <= STATUS_POOL_FULL;
            endcase
            fkey_reg <= (res_kind_reg == RES_FOUND) ? rkey_q : '0;
            fpay_reg <= (res_kind_reg == RES_FOUND) ? rpay_q : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status        = status_reg;
    assign found_key     = fkey_reg;
    assign found_payload = fpay_reg;
    assign out_valid     = out_valid_reg;

    assign sts.mode       = mode_reg;
    assign sts.div_last   = (div_cnt_reg == DIV_CNT_W'(1));
    assign sts.head_valid = head_valid_reg[bucket];
    assign sts.pool_full  = (alloc_cnt_reg == AW'(POOL_PAGES));
    assign sts.next_valid = meta_nv;
    assign sts.page_full  = (meta_fill >= eff_rpp);
    assign sts.idx_end    = (idx_reg >= meta_fill);
    assign sts.key_match  = (rkey_q == key_reg);
    assign sts.out_hold   = out_valid_reg & out_stall;

    assert property (@(posedge clk) disable iff (!rst_n)
        alloc_cnt_reg <= AW'(POOL_PAGES))
        else $error("page pool overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_wr |-> !sts.pool_full)
        else $error("page taken from exhausted pool");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != STATUS_OK |-> fkey_reg == '0 && fpay_reg == '0)
        else $error("record data on a failed transaction");

endmodule

### hw/rtl/hash_index_overflow_chain_core.sv
// Top level of the hash index overflow chain core.
// One transaction at a time. After the accepting cycle, a bit-serial remainder
// finds the key's bucket. The bucket head is then read and checked, and an
// insert into an empty bucket is stored during that check. An insert walks
// the chain, reading and checking each page's metadata, and appends during
// the last page check. When it has to link a fresh page, it then links the
// last page and allocates the fresh one. A lookup also scans each page's
// records, reading and checking one record at a time. The result is then
// loaded into the output register once that register is free. A finished
// result waits in the output register while the next transaction is
// accepted. Reset clears the bucket-head valid bits at once; no clearing pass
// is needed.
module hash_index_overflow_chain_core #(
    parameter int MAX_BUCKETS       = hicp_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_PAGES        = hicp_pkg::DEF_POOL_PAGES,
    parameter int MAX_RECS_PER_PAGE = hicp_pkg::DEF_MAX_RECS_PER_PAGE,
    parameter int PAYLOAD_BITS      = hicp_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hicp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hicp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [hicp_pkg::KEY_W-1:0]       key,
    input  logic [PAYLOAD_BITS-1:0]          payload,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [hicp_pkg::KEY_W-1:0]       found_key,
    output logic [PAYLOAD_BITS-1:0]          found_payload
);
    import hicp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    hicp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    hicp_dp #(
        .MAX_BUCKETS       (MAX_BUCKETS),
        .POOL_PAGES        (POOL_PAGES),
        .MAX_RECS_PER_PAGE (MAX_RECS_PER_PAGE),
        .PAYLOAD_BITS      (PAYLOAD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .key           (key),
        .payload       (payload),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .found_key     (found_key),
        .found_payload (found_payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

endmodule

### sim/hash_index_overflow_chain_core_test.sv
// Testbench for the hash index overflow chain core: random and directed traffic against a table model.
`timescale 1ns / 1ps

module hash_index_overflow_chain_core_test;
    import hicp_pkg::*;

    localparam int BUCKETS  = 256;
    localparam int PAGES    = 1024;
    localparam int PAGE_RECS = 8;
    localparam int WATCHDOG = 20000;

    typedef struct {
        status_t      status;
        logic [30:0]  key;
        logic [63:0]  payload;
    } lookup_result_t;

    class chain_table_scoreboard;
        int                 errors;
        lookup_result_t     pending_results[$];
        logic [8:0]         buckets_reg;
        logic [3:0]         recs_reg;
        bit                 head_ok [BUCKETS];
        bit [9:0]           head_page [BUCKETS];
        bit                 link_ok [PAGES];
        bit [9:0]           link_page [PAGES];
        bit [3:0]           fill [PAGES];
        bit [30:0]          rec_key [PAGES*PAGE_RECS];
        bit [63:0]          rec_data [PAGES*PAGE_RECS];
        int                 pages_used;

        function new();
            errors = 0;
            buckets_reg = BC_RESET;
            recs_reg = RPP_RESET;
            pages_used = 0;
            foreach (head_ok[i]) head_ok[i] = 0;
        endfunction

        task flag(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BUCKET_COUNT)
                buckets_reg = data[8:0];
            else
                recs_reg = data[3:0];
        endfunction

        function int live_buckets();
            if (buckets_reg == 0) return 1;
            if (buckets_reg > BUCKETS) return BUCKETS;
            return buckets_reg;
        endfunction

        function int live_recs();
            if (recs_reg == 0) return 1;
            if (recs_reg > PAGE_RECS) return PAGE_RECS;
            return recs_reg;
        endfunction

        function bit grab_page(output int pg);
            if (pages_used >= PAGES) return 0;
            pg = pages_used;
            pages_used++;
            link_ok[pg] = 0;
            link_page[pg] = 0;
            fill[pg] = 0;
            return 1;
        endfunction

        function void note_request(logic m, logic [30:0] k, logic [63:0] p);
            lookup_result_t r;
            int b, pg, fresh, slot, n;
            bit done;
            r.status = STATUS_OK;
            r.key = '0;
            r.payload = '0;
            b = k % live_buckets();
            done = 0;
            if (m == MODE_INSERT) begin
                if (!head_ok[b]) begin
                    if (!grab_page(pg)) begin
                        r.status = STATUS_POOL_FULL;
                        done = 1;
                    end else begin
                        head_page[b] = 10'(pg);
                        head_ok[b] = 1;
                    end
                end else begin
                    pg = head_page[b];
                    while (link_ok[pg]) pg = link_page[pg];
                    if (fill[pg] >= live_recs()) begin
                        if (!grab_page(fresh)) begin
                            r.status = STATUS_POOL_FULL;
                            done = 1;
                        end else begin
                            link_page[pg] = 10'(fresh);
                            link_ok[pg] = 1;
                            pg = fresh;
                        end
                    end
                end
                if (!done) begin
                    slot = pg * PAGE_RECS + (fill[pg] % PAGE_RECS);
                    rec_key[slot] = k;
                    rec_data[slot] = p;
                    fill[pg]++;
                end
            end else begin
                r.status = STATUS_NOT_FOUND;
                if (head_ok[b]) begin
                    pg = head_page[b];
                    while (!done) begin
                        n = (fill[pg] > PAGE_RECS) ? PAGE_RECS : fill[pg];
                        for (int i = 0; i < n && !done; i++) begin
                            slot = pg * PAGE_RECS + i;
                            if (rec_key[slot] == k) begin
                                r.status = STATUS_OK;
                                r.key = rec_key[slot];
                                r.payload = rec_data[slot];
                                done = 1;
                            end
                        end
                        if (!link_ok[pg]) done = 1;
                        else pg = link_page[pg];
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        task check_response(logic [1:0] st, logic [30:0] k, logic [63:0] p);
            lookup_result_t e;
            if (pending_results.size() == 0) begin
                flag("result with nothing outstanding");
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
                flag($sformatf("status %0d, want %0d", st, e.status));
            if (k !== e.key)
                flag($sformatf("found_key %h, want %h", k, e.key));
            if (p !== e.payload)
                flag($sformatf("found_payload %h, want %h", p, e.payload));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   mode;
    logic [KEY_W-1:0]       key;
    logic [63:0]            payload;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             status;
    logic [KEY_W-1:0]       found_key;
    logic [63:0]            found_payload;

    chain_table_scoreboard  sb;
    logic [30:0]            key_history[$];
    bit                     no_gaps;
    int                     stall_left;
    int                     idle_cycles;

    hash_index_overflow_chain_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_key     (found_key),
        .found_payload (found_payload)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // result side: random stall per transaction, checked at acceptance
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_response(status, found_key, found_payload);
            stall_left = no_gaps ? 0 : $urandom_range(0, 11);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task send_item(logic m, logic [30:0] k, logic [63:0] p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        key <= k;
        payload <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(m, k, p);
        if (m == MODE_INSERT) begin
            key_history.push_back(k);
            if (key_history.size() > 64) void'(key_history.pop_front());
        end
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    function logic [30:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && key_history.size() > 0)
            return key_history[$urandom_range(0, key_history.size() - 1)];
        if (sel < 6)
            return 31'($urandom_range(0, 600));
        return 31'($urandom);
    endfunction

    task random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_drained();
            send_item($urandom_range(0, 99) < 55 ? MODE_INSERT : MODE_LOOKUP,
                      pick_key(), {$urandom, $urandom});
        end
    endtask

    initial
    begin
        int bc_list [6];
        int rpp_list [6];
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_INSERT;
        key = '0;
        payload = '0;
        out_stall = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        no_gaps = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, empty bucket, miss in a used bucket, duplicates
        send_item(MODE_LOOKUP, 31'd5, 64'd0);
        send_item(MODE_INSERT, 31'd0, 64'd0);
        send_item(MODE_INSERT, 31'h7FFFFFFF, 64'hFFFFFFFFFFFFFFFF);
        send_item(MODE_LOOKUP, 31'd0, 64'hFFFFFFFFFFFFFFFF);
        send_item(MODE_LOOKUP, 31'h7FFFFFFF, 64'd0);
        send_item(MODE_LOOKUP, 31'd256, 64'd0);
        send_item(MODE_INSERT, 31'd512, 64'h1111);
        send_item(MODE_INSERT, 31'd512, 64'h2222);
        send_item(MODE_LOOKUP, 31'd512, 64'd0);
        wait_drained();
        write_reg(REG_BUCKET_COUNT, 9'd0);
        write_reg(REG_RECS_PER_PAGE, 9'd0);
        for (int i = 0; i < 4; i++)
            send_item(MODE_INSERT, 31'(1000 + i), 64'hA5A5000000000000 | 64'(i));
        send_item(MODE_LOOKUP, 31'd1003, 64'd0);
        send_item(MODE_LOOKUP, 31'd512, 64'd0);
        send_item(MODE_LOOKUP, 31'd7, 64'd0);
        wait_drained();
        write_reg(REG_BUCKET_COUNT, 9'h1FF);
        write_reg(REG_RECS_PER_PAGE, 9'h1FF);
        send_item(MODE_LOOKUP, 31'd1003, 64'd0);
        send_item(MODE_INSERT, 31'd300, 64'h5A5A5A5A5A5A5A5A);
        send_item(MODE_LOOKUP, 31'd300, 64'd0);
        wait_drained();

        bc_list = '{1, 7, 256, 100, 511, 3};
        rpp_list = '{3, 1, 8, 2, 15, 5};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(bc_list[ph]));
            write_reg(REG_RECS_PER_PAGE, CFG_DATA_W'(rpp_list[ph]));
            no_gaps = (ph % 3 == 2);
            random_phase(ph == 0 ? 60 : 100);
            wait_drained();
        end

        // one record per page, so every insert into a used bucket must link a fresh page
        no_gaps = 0;
        write_reg(REG_BUCKET_COUNT, 9'd256);
        write_reg(REG_RECS_PER_PAGE, 9'd1);
        random_phase(60);
        wait_drained();

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
